FILE: src/tchp_pkg.sv
// shared types and constants for the client hello extension parser
`timescale 1ns / 1ps

package tchp_pkg;

    localparam logic [15:0] SUPPORTED_VERSIONS_TYPE = 16'h002b;
    localparam logic [15:0] GREASE_MASK             = 16'h0f0f;
    localparam logic [15:0] GREASE_PATTERN          = 16'h0a0a;
    localparam logic [15:0] RANDOM_BYTES            = 16'd32;
    localparam logic [24:0] OFFSET_MAX              = 25'h1ffffff;

    localparam logic KIND_EXTENSION = 1'b0;
    localparam logic KIND_STATUS    = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] extension_type;
        logic [15:0] extension_length;
        logic        parse_status;
        logic [15:0] highest_version;
        logic [14:0] extension_count;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic    ext_valid;
        logic    fin_valid;
        result_t ext_item;
        result_t fin_item;
    } emit_t;

endpackage

FILE: src/tls_client_hello_extension_parser.sv
// top level of the client hello extension parser: byte stream in, results out
// output: each result is queued as its byte is accepted and offered behind older ones
// throughput: one byte per cycle while s_tready is high; a final byte that ends an
//   extension header gives two results, drained one per cycle while m_tready is high
// reset: rst_n clears the parse state and empties the result queue at once
`timescale 1ns / 1ps

module tls_client_hello_extension_parser
#(
    parameter int FIFO_AW = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // extension_type, extension_length, parse_status, highest_version, extension_count
    output logic [63:0] m_tdata,
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // run_end
);

    localparam int DEPTH = 2 ** FIFO_AW;

    logic              s_acc;
    logic [FIFO_AW:0]  level;
    tchp_pkg::emit_t   emit;
    tchp_pkg::result_t head;

    // keep room for the two items one byte can cause
    assign s_tready = (level <= (FIFO_AW + 1)'(DEPTH - 2));
    assign s_acc    = s_tvalid && s_tready;

    tchp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_acc),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .emit       (emit)
    );

    tchp_fifo #(.AW(FIFO_AW)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s_acc),
        .emit  (emit),
        .pop   (m_tready),
        .level (level),
        .head  (head)
    );

    assign m_tvalid = (level != '0);
    assign m_tdata  = {head.extension_count, head.highest_version, head.parse_status,
                       head.extension_length, head.extension_type};
    assign m_tuser  = head.result_kind;
    assign m_tlast  = head.run_end;

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= (FIFO_AW + 1)'(DEPTH))
        else $error("result queue overflow");

    a_final_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tlast |=> m_tvalid)
        else $error("final byte gave no result");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status item not marked last");

    a_ext_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[48:32] == 17'd0)
        else $error("extension item carries status fields");
`endif

endmodule

FILE: src/tchp_parser.sv
// byte-wise client hello walker: phase, length counters and version tracking
`timescale 1ns / 1ps

module tchp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    output tchp_pkg::emit_t  emit
);

    typedef enum logic [15:0] {
        PH_TYPE    = 16'h0001,
        PH_MSGLEN  = 16'h0002,
        PH_VERSION = 16'h0004,
        PH_RANDOM  = 16'h0008,
        PH_SIDLEN  = 16'h0010,
        PH_SID     = 16'h0020,
        PH_CSLEN   = 16'h0040,
        PH_CS      = 16'h0080,
        PH_COMPLEN = 16'h0100,
        PH_COMP    = 16'h0200,
        PH_EXTLEN  = 16'h0400,
        PH_HDR     = 16'h0800,
        PH_BODY    = 16'h1000,
        PH_SVLEN   = 16'h2000,
        PH_SVBODY  = 16'h4000,
        PH_TAIL    = 16'h8000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [24:0] offset_reg, offset_next;
    logic [23:0] msg_len_reg, msg_len_next;
    logic [15:0] field_rem_reg, field_rem_next;
    logic [15:0] block_rem_reg, block_rem_next;
    logic [15:0] body_rem_reg, body_rem_next;
    logic [15:0] etype_reg, etype_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  ver_rem_reg, ver_rem_next;
    logic [7:0]  ver_hi_reg, ver_hi_next;
    logic [15:0] cand_reg, cand_next;
    logic [15:0] best_reg, best_next;
    logic [14:0] ext_cnt_reg, ext_cnt_next;
    logic        err_reg, err_next;

    logic        go_next;
    logic [15:0] go_block;
    logic [15:0] field_dec;
    logic [15:0] block_dec;
    logic [15:0] body_dec;
    logic [15:0] hdr_len;
    logic [15:0] ver_word;
    logic        bad;

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        msg_len_next   = msg_len_reg;
        field_rem_next = field_rem_reg;
        block_rem_next = block_rem_reg;
        body_rem_next  = body_rem_reg;
        etype_next     = etype_reg;
        hdr_idx_next   = hdr_idx_reg;
        ver_rem_next   = ver_rem_reg;
        ver_hi_next    = ver_hi_reg;
        cand_next      = cand_reg;
        best_next      = best_reg;
        ext_cnt_next   = ext_cnt_reg;
        err_next       = err_reg;
        go_next        = 1'b0;
        go_block       = block_rem_reg;
        emit           = '0;

        field_dec = (field_rem_reg != 16'd0) ? field_rem_reg - 16'd1 : field_rem_reg;
        block_dec = (block_rem_reg != 16'd0) ? block_rem_reg - 16'd1 : block_rem_reg;
        body_dec  = (body_rem_reg != 16'd0) ? body_rem_reg - 16'd1 : body_rem_reg;
        hdr_len   = {field_rem_reg[7:0], data_byte};
        ver_word  = {ver_hi_reg, data_byte};

        if (phase_reg != PH_TYPE && phase_reg != PH_MSGLEN && offset_reg != tchp_pkg::OFFSET_MAX)
        begin
            offset_next = offset_reg + 25'd1;
        end

        case (phase_reg)
            PH_TYPE:
            begin
                phase_next   = PH_MSGLEN;
                hdr_idx_next = 2'd0;
                msg_len_next = 24'd0;
            end
            PH_MSGLEN:
            begin
                msg_len_next = {msg_len_reg[15:0], data_byte};
                if (hdr_idx_reg >= 2'd2)
                begin
                    phase_next     = PH_VERSION;
                    field_rem_next = 16'd2;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                end
            end
            PH_VERSION, PH_RANDOM, PH_SID, PH_CS, PH_COMP:
            begin
                field_rem_next = field_dec;
                if (field_dec == 16'd0)
                begin
                    case (phase_reg)
                        PH_VERSION:
                        begin
                            phase_next     = PH_RANDOM;
                            field_rem_next = tchp_pkg::RANDOM_BYTES;
                        end
                        PH_RANDOM: phase_next = PH_SIDLEN;
                        PH_SID:
                        begin
                            phase_next   = PH_CSLEN;
                            hdr_idx_next = 2'd0;
                        end
                        PH_CS: phase_next = PH_COMPLEN;
                        default:
                        begin
                            phase_next   = PH_EXTLEN;
                            hdr_idx_next = 2'd0;
                        end
                    endcase
                end
            end
            PH_SIDLEN:
            begin
                field_rem_next = {8'd0, data_byte};
                hdr_idx_next   = 2'd0;
                phase_next     = (data_byte == 8'd0) ? PH_CSLEN : PH_SID;
            end
            PH_CSLEN:
            begin
                field_rem_next = hdr_len;
                if (hdr_idx_reg != 2'd0)
                begin
                    phase_next = (hdr_len == 16'd0) ? PH_COMPLEN : PH_CS;
                end
                else
                begin
                    hdr_idx_next = 2'd1;
                end
            end
            PH_COMPLEN:
            begin
                field_rem_next = {8'd0, data_byte};
                hdr_idx_next   = 2'd0;
                phase_next     = (data_byte == 8'd0) ? PH_EXTLEN : PH_COMP;
            end
            PH_EXTLEN:
            begin
                block_rem_next = {block_rem_reg[7:0], data_byte};
                if (hdr_idx_reg != 2'd0)
                begin
                    go_next  = 1'b1;
                    go_block = {block_rem_reg[7:0], data_byte};
                end
                else
                begin
                    hdr_idx_next = 2'd1;
                end
            end
            PH_HDR:
            begin
                block_rem_next = block_dec;
                case (hdr_idx_reg)
                    2'd0: etype_next = {8'd0, data_byte};
                    2'd1: etype_next = {etype_reg[7:0], data_byte};
                    2'd2: field_rem_next = {8'd0, data_byte};
                    default: field_rem_next = hdr_len;
                endcase
                if (hdr_idx_reg != 2'd3)
                begin
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                end
                else
                begin
                    hdr_idx_next = 2'd0;
                    if (hdr_len > block_dec)
                    begin
                        // body would run past the block
                        err_next   = 1'b1;
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        ext_cnt_next                    = ext_cnt_reg + 15'd1;
                        emit.ext_valid                  = 1'b1;
                        emit.ext_item.result_kind       = tchp_pkg::KIND_EXTENSION;
                        emit.ext_item.extension_type    = etype_reg;
                        emit.ext_item.extension_length  = hdr_len;
                        emit.ext_item.extension_count   = ext_cnt_reg + 15'd1;
                        emit.ext_item.run_end           = !final_byte;
                        body_rem_next                   = hdr_len;
                        if (etype_reg == tchp_pkg::SUPPORTED_VERSIONS_TYPE &&
                            hdr_len >= 16'd3)
                        begin
                            phase_next = PH_SVLEN;
                        end
                        else if (hdr_len == 16'd0)
                        begin
                            go_next  = 1'b1;
                            go_block = block_dec;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                body_rem_next  = body_dec;
                block_rem_next = block_dec;
                if (body_dec == 16'd0)
                begin
                    go_next  = 1'b1;
                    go_block = block_dec;
                end
            end
            PH_SVLEN:
            begin
                body_rem_next  = body_dec;
                block_rem_next = block_dec;
                // list length plus its own byte must fit the body
                if ({8'd0, data_byte} < field_rem_reg)
                begin
                    ver_rem_next = data_byte;
                    cand_next    = 16'd0;
                    hdr_idx_next = 2'd0;
                    phase_next   = PH_SVBODY;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
                if (body_dec == 16'd0)
                begin
                    go_next  = 1'b1;
                    go_block = block_dec;
                end
            end
            PH_SVBODY:
            begin
                if (ver_rem_reg != 8'd0)
                begin
                    if (hdr_idx_reg == 2'd0)
                    begin
                        if (ver_rem_reg >= 8'd2)
                        begin
                            ver_hi_next  = data_byte;
                            hdr_idx_next = 2'd1;
                        end
                    end
                    else
                    begin
                        hdr_idx_next = 2'd0;
                        if ((ver_word & tchp_pkg::GREASE_MASK) != tchp_pkg::GREASE_PATTERN &&
                            ver_word > cand_reg)
                        begin
                            cand_next = ver_word;
                        end
                    end
                    ver_rem_next = ver_rem_reg - 8'd1;
                end
                body_rem_next  = body_dec;
                block_rem_next = block_dec;
                if (body_dec == 16'd0)
                begin
                    if (cand_next != 16'd0)
                    begin
                        best_next = cand_next;
                    end
                    go_next  = 1'b1;
                    go_block = block_dec;
                end
            end
            PH_TAIL:
            begin
            end
            default:
            begin
            end
        endcase

        // step to the next extension header, skip a short tail, or stop when the block is used up
        if (go_next)
        begin
            if (go_block == 16'd0)
            begin
                phase_next = PH_TAIL;
            end
            else if (go_block < 16'd4)
            begin
                body_rem_next = go_block;
                phase_next    = PH_BODY;
            end
            else
            begin
                hdr_idx_next = 2'd0;
                phase_next   = PH_HDR;
            end
        end

        bad = err_next || !(phase_next == PH_EXTLEN || phase_next == PH_TAIL) ||
              (offset_next < {1'b0, msg_len_next});

        if (final_byte)
        begin
            emit.fin_valid                = 1'b1;
            emit.fin_item.result_kind     = tchp_pkg::KIND_STATUS;
            emit.fin_item.parse_status    = bad;
            emit.fin_item.highest_version = best_next;
            emit.fin_item.extension_count = ext_cnt_next;
            emit.fin_item.run_end         = 1'b1;

            phase_next     = PH_TYPE;
            offset_next    = 25'd0;
            msg_len_next   = 24'd0;
            field_rem_next = 16'd0;
            block_rem_next = 16'd0;
            body_rem_next  = 16'd0;
            etype_next     = 16'd0;
            hdr_idx_next   = 2'd0;
            ver_rem_next   = 8'd0;
            ver_hi_next    = 8'd0;
            cand_next      = 16'd0;
            best_next      = 16'd0;
            ext_cnt_next   = 15'd0;
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            offset_reg    <= 25'd0;
            msg_len_reg   <= 24'd0;
            field_rem_reg <= 16'd0;
            block_rem_reg <= 16'd0;
            body_rem_reg  <= 16'd0;
            etype_reg     <= 16'd0;
            hdr_idx_reg   <= 2'd0;
            ver_rem_reg   <= 8'd0;
            ver_hi_reg    <= 8'd0;
            cand_reg      <= 16'd0;
            best_reg      <= 16'd0;
            ext_cnt_reg   <= 15'd0;
            err_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            msg_len_reg   <= msg_len_next;
            field_rem_reg <= field_rem_next;
            block_rem_reg <= block_rem_next;
            body_rem_reg  <= body_rem_next;
            etype_reg     <= etype_next;
            hdr_idx_reg   <= hdr_idx_next;
            ver_rem_reg   <= ver_rem_next;
            ver_hi_reg    <= ver_hi_next;
            cand_reg      <= cand_next;
            best_reg      <= best_next;
            ext_cnt_reg   <= ext_cnt_next;
            err_reg       <= err_next;
        end
    end

endmodule

FILE: src/tchp_fifo.sv
// result queue that takes up to two items per cycle and delivers one on each pop
`timescale 1ns / 1ps

module tchp_fifo
#(
    parameter int AW = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tchp_pkg::emit_t   emit,
    input  logic              pop,
    output logic [AW:0]       level,
    output tchp_pkg::result_t head
);

    localparam int DEPTH = 2 ** AW;

    tchp_pkg::result_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   level_reg, level_next;
    logic [1:0]    n_push;
    logic          do_pop;
    tchp_pkg::result_t first_item;

    assign n_push     = push ? ({1'b0, emit.ext_valid} + {1'b0, emit.fin_valid}) : 2'd0;
    assign first_item = emit.ext_valid ? emit.ext_item : emit.fin_item;
    assign do_pop     = pop && (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(n_push);
        rd_ptr_next = rd_ptr_reg + AW'(do_pop);
        level_next  = level_reg + (AW + 1)'(n_push) - (AW + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= first_item;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= emit.fin_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign level = level_reg;
    assign head  = mem[rd_ptr_reg];

endmodule

FILE: tb/tb_tls_client_hello_extension_parser.sv
// self-checking testbench for the client hello extension parser
`timescale 1ns / 1ps

module tb_tls_client_hello_extension_parser;

    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          BYTE_TARGET   = 1100;
    localparam logic [7:0]  HELLO_TYPE    = 8'h01;
    localparam logic [15:0] TLS12_VERSION = 16'h0303;
    localparam logic [15:0] TLS13_VERSION = 16'h0304;
    localparam logic        STATUS_OK     = 1'b0;

    typedef enum logic [3:0] {
        PH_TYPE, PH_MSGLEN, PH_VERSION, PH_RANDOM, PH_SIDLEN, PH_SID,
        PH_CSLEN, PH_CS, PH_COMPLEN, PH_COMP, PH_EXTLEN, PH_HDR,
        PH_BODY, PH_SVLEN, PH_SVBODY, PH_TAIL
    } parse_phase_e;

    typedef enum int {
        HC_PLAIN, HC_NO_EXT, HC_ONE_TAIL_BYTE, HC_OVERRUN, HC_SHORT_TAIL,
        HC_AFTER_BLOCK, HC_ODD_LIST, HC_LONG_DECL, HC_TRUNCATED, HC_NOISE
    } hello_case_e;

    class hello_scoreboard;
        parse_phase_e       phase;
        logic [24:0]        after_hdr;
        logic [23:0]        msg_len;
        logic [15:0]        field_left;
        logic [15:0]        block_left;
        logic [15:0]        ext_left;
        logic [15:0]        cur_type;
        logic [1:0]         hdr_idx;
        logic [7:0]         vers_left;
        logic [7:0]         ver_hi;
        logic [15:0]        cand_hi;
        logic [15:0]        kept_hi;
        logic [14:0]        ext_count;
        logic               err;
        tchp_pkg::result_t  expected_q[$];
        int                 mismatches;
        int                 bytes_noted;
        int                 ext_results;
        int                 status_results;
        int                 malformed;

        function new();
            clear_parse();
            mismatches = 0;
            bytes_noted = 0;
            ext_results = 0;
            status_results = 0;
            malformed = 0;
        endfunction

        function void clear_parse();
            phase = PH_TYPE;
            after_hdr = '0;
            msg_len = '0;
            field_left = '0;
            block_left = '0;
            ext_left = '0;
            cur_type = '0;
            hdr_idx = '0;
            vers_left = '0;
            ver_hi = '0;
            cand_hi = '0;
            kept_hi = '0;
            ext_count = '0;
            err = 1'b0;
        endfunction

        function tchp_pkg::result_t make_result(logic kind, logic [15:0] etype,
                                                logic [15:0] elen, logic status,
                                                logic [15:0] hi, logic [14:0] cnt);
            tchp_pkg::result_t r;
            r.result_kind = kind;
            r.extension_type = etype;
            r.extension_length = elen;
            r.parse_status = status;
            r.highest_version = hi;
            r.extension_count = cnt;
            r.run_end = 1'b0;
            return r;
        endfunction

        function void next_extension();
            if (block_left == 0)
                phase = PH_TAIL;
            else if (block_left < 16'd4)
            begin
                ext_left = block_left;
                phase = PH_BODY;
            end
            else
            begin
                hdr_idx = 0;
                phase = PH_HDR;
            end
        endfunction

        function void consume_body_byte();
            if (ext_left > 0)
                ext_left--;
            if (block_left > 0)
                block_left--;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            tchp_pkg::result_t made_q[$];
            logic [15:0]       ver;
            logic              bad;
            bytes_noted++;
            if (phase >= PH_VERSION && after_hdr != tchp_pkg::OFFSET_MAX)
                after_hdr++;
            case (phase)
                PH_TYPE:
                begin
                    phase = PH_MSGLEN;
                    hdr_idx = 0;
                    msg_len = '0;
                end
                PH_MSGLEN:
                begin
                    msg_len = {msg_len[15:0], b};
                    if (hdr_idx >= 2)
                    begin
                        phase = PH_VERSION;
                        field_left = 16'd2;
                    end
                    else
                        hdr_idx++;
                end
                PH_VERSION, PH_RANDOM, PH_SID, PH_CS, PH_COMP:
                begin
                    if (field_left > 0)
                        field_left--;
                    if (field_left == 0)
                    begin
                        case (phase)
                            PH_VERSION:
                            begin
                                phase = PH_RANDOM;
                                field_left = tchp_pkg::RANDOM_BYTES;
                            end
                            PH_RANDOM: phase = PH_SIDLEN;
                            PH_SID:
                            begin
                                phase = PH_CSLEN;
                                hdr_idx = 0;
                            end
                            PH_CS: phase = PH_COMPLEN;
                            default:
                            begin
                                phase = PH_EXTLEN;
                                hdr_idx = 0;
                            end
                        endcase
                    end
                end
                PH_SIDLEN:
                begin
                    field_left = {8'h00, b};
                    hdr_idx = 0;
                    phase = (b == 0) ? PH_CSLEN : PH_SID;
                end
                PH_CSLEN:
                begin
                    field_left = {field_left[7:0], b};
                    if (hdr_idx >= 1)
                        phase = (field_left == 0) ? PH_COMPLEN : PH_CS;
                    else
                        hdr_idx = 1;
                end
                PH_COMPLEN:
                begin
                    field_left = {8'h00, b};
                    hdr_idx = 0;
                    phase = (b == 0) ? PH_EXTLEN : PH_COMP;
                end
                PH_EXTLEN:
                begin
                    block_left = {block_left[7:0], b};
                    if (hdr_idx >= 1)
                        next_extension();
                    else
                        hdr_idx = 1;
                end
                PH_HDR:
                begin
                    if (block_left > 0)
                        block_left--;
                    case (hdr_idx)
                        2'd0: cur_type = {8'h00, b};
                        2'd1: cur_type = {cur_type[7:0], b};
                        2'd2: field_left = {8'h00, b};
                        default: field_left = {field_left[7:0], b};
                    endcase
                    if (hdr_idx < 3)
                        hdr_idx++;
                    else
                    begin
                        hdr_idx = 0;
                        // a body that cannot fit in the block poisons the rest of the message
                        if (field_left > block_left)
                        begin
                            err = 1'b1;
                            phase = PH_TAIL;
                        end
                        else
                        begin
                            ext_count++;
                            made_q.push_back(make_result(tchp_pkg::KIND_EXTENSION, cur_type,
                                                         field_left, STATUS_OK, 16'h0000,
                                                         ext_count));
                            ext_results++;
                            ext_left = field_left;
                            if (cur_type == tchp_pkg::SUPPORTED_VERSIONS_TYPE
                                && field_left >= 16'd3)
                                phase = PH_SVLEN;
                            else if (field_left == 0)
                                next_extension();
                            else
                                phase = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    consume_body_byte();
                    if (ext_left == 0)
                        next_extension();
                end
                PH_SVLEN:
                begin
                    consume_body_byte();
                    if ({8'h00, b} + 16'd1 <= field_left)
                    begin
                        vers_left = b;
                        cand_hi = '0;
                        hdr_idx = 0;
                        phase = PH_SVBODY;
                    end
                    else
                        phase = PH_BODY;
                    if (ext_left == 0)
                        next_extension();
                end
                PH_SVBODY:
                begin
                    if (vers_left > 0)
                    begin
                        if (hdr_idx == 0)
                        begin
                            // a lone trailing list byte is dropped
                            if (vers_left >= 8'd2)
                            begin
                                ver_hi = b;
                                hdr_idx = 1;
                            end
                        end
                        else
                        begin
                            ver = {ver_hi, b};
                            hdr_idx = 0;
                            if ((ver & tchp_pkg::GREASE_MASK) != tchp_pkg::GREASE_PATTERN
                                && ver > cand_hi)
                                cand_hi = ver;
                        end
                        vers_left--;
                    end
                    consume_body_byte();
                    if (ext_left == 0)
                    begin
                        if (cand_hi != 0)
                            kept_hi = cand_hi;
                        next_extension();
                    end
                end
                default: ;
            endcase
            if (fin)
            begin
                bad = err || (phase < PH_EXTLEN) || (phase > PH_EXTLEN && phase < PH_TAIL)
                      || (after_hdr < {1'b0, msg_len});
                made_q.push_back(make_result(tchp_pkg::KIND_STATUS, 16'h0000, 16'h0000, bad,
                                             kept_hi, ext_count));
                status_results++;
                if (bad)
                    malformed++;
                clear_parse();
            end
            if (made_q.size() > 0)
                made_q[made_q.size() - 1].run_end = 1'b1;
            foreach (made_q[i])
                expected_q.push_back(made_q[i]);
        endfunction

        function string describe(tchp_pkg::result_t r);
            return $sformatf("kind=%0d type=%h len=%h status=%0d hi=%h count=%0d end=%0d",
                             r.result_kind, r.extension_type, r.extension_length,
                             r.parse_status, r.highest_version, r.extension_count, r.run_end);
        endfunction

        function void check_result(tchp_pkg::result_t got);
            tchp_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: %s", $realtime, describe(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind
                || got.extension_type !== want.extension_type
                || got.extension_length !== want.extension_length
                || got.parse_status !== want.parse_status
                || got.highest_version !== want.highest_version
                || got.extension_count !== want.extension_count
                || got.run_end !== want.run_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result differs", $realtime);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    hello_scoreboard sb;
    logic [7:0]      hello_bytes[$];

    tls_client_hello_extension_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push16(ref logic [7:0] q[$], input logic [15:0] v);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endfunction

    // lays out one client hello in hello_bytes, shaped by the chosen case
    task automatic build_hello(input hello_case_e hc);
        logic [7:0]  body[$];
        logic [7:0]  block[$];
        logic [7:0]  ext_body[$];
        logic [15:0] ext_kind;
        logic [15:0] ver;
        logic [23:0] decl_len;
        int          pick;
        int          sid_len;
        int          cs_len;
        int          cm_len;
        int          n_ext;
        int          n_ver;
        int          vers_len;
        int          ext_len;
        int          cut;
        hello_bytes.delete();
        if (hc == HC_NOISE)
        begin
            repeat ($urandom_range(1, 60))
                hello_bytes.push_back(8'($urandom));
            return;
        end
        push16(body, TLS12_VERSION);
        repeat (32)
            body.push_back(8'($urandom));
        pick = $urandom_range(0, 39);
        sid_len = (pick < 16) ? $urandom_range(1, 8) : (pick < 36) ? 0 : (pick < 39) ? 32 : 255;
        body.push_back(8'(sid_len));
        repeat (sid_len)
            body.push_back(8'($urandom));
        cs_len = ($urandom_range(0, 9) == 0) ? 0 : 2 * $urandom_range(1, 4);
        push16(body, 16'(cs_len));
        repeat (cs_len)
            body.push_back(8'($urandom));
        cm_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 1;
        body.push_back(8'(cm_len));
        repeat (cm_len)
            body.push_back(8'($urandom));
        if (hc == HC_ONE_TAIL_BYTE)
            body.push_back(8'($urandom));
        else if (hc != HC_NO_EXT)
        begin
            n_ext = (hc == HC_PLAIN || hc == HC_ODD_LIST) ? $urandom_range(1, 4)
                                                           : $urandom_range(0, 3);
            for (int e = 0; e < n_ext; e++)
            begin
                pick = $urandom_range(0, 5);
                ext_kind = (pick < 2) ? tchp_pkg::SUPPORTED_VERSIONS_TYPE :
                           (pick == 2) ? 16'h0000 :
                           (pick == 3) ? 16'hffff : 16'($urandom);
                if (hc == HC_ODD_LIST && e == 0)
                    ext_kind = tchp_pkg::SUPPORTED_VERSIONS_TYPE;
                ext_body.delete();
                if (ext_kind == tchp_pkg::SUPPORTED_VERSIONS_TYPE)
                begin
                    pick = (hc == HC_ODD_LIST && e == 0) ? 1 : $urandom_range(0, 9);
                    if (pick == 0)
                    begin
                        // too short to carry a version list
                        repeat ($urandom_range(0, 2))
                            ext_body.push_back(8'($urandom));
                    end
                    else
                    begin
                        n_ver = $urandom_range(0, 4);
                        vers_len = 2 * n_ver + ((pick == 1) ? 1 : 0);
                        // list length claiming more than the body holds
                        ext_body.push_back(8'(vers_len + ((pick == 2) ? $urandom_range(1, 250)
                                                                      : 0)));
                        repeat (n_ver)
                        begin
                            case ($urandom_range(0, 3))
                                0: ver = {4'($urandom), 4'ha, 4'($urandom), 4'ha};
                                1: ver = TLS13_VERSION;
                                2: ver = TLS12_VERSION;
                                default: ver = 16'($urandom);
                            endcase
                            push16(ext_body, ver);
                        end
                        if (pick == 1)
                            ext_body.push_back(8'($urandom));
                        if (pick == 3)
                            repeat ($urandom_range(1, 3))
                                ext_body.push_back(8'($urandom));
                    end
                end
                else
                    repeat ($urandom_range(0, 6))
                        ext_body.push_back(8'($urandom));
                push16(block, ext_kind);
                push16(block, 16'(ext_body.size()));
                foreach (ext_body[i])
                    block.push_back(ext_body[i]);
            end
            if (hc == HC_OVERRUN || $urandom_range(0, 19) == 0)
            begin
                ext_len = $urandom_range(0, 4);
                push16(block, 16'($urandom));
                push16(block, ($urandom_range(0, 3) == 0) ? 16'hffff
                                                          : 16'(ext_len + $urandom_range(1, 400)));
                repeat (ext_len)
                    block.push_back(8'($urandom));
            end
            if (hc == HC_SHORT_TAIL || $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    block.push_back(8'($urandom));
            push16(body, 16'(block.size()));
            foreach (block[i])
                body.push_back(block[i]);
            if (hc == HC_AFTER_BLOCK || $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    body.push_back(8'($urandom));
        end
        decl_len = 24'(body.size());
        if (hc == HC_LONG_DECL)
            decl_len = ($urandom_range(0, 3) == 0) ? 24'hffffff
                                                   : decl_len + 24'($urandom_range(1, 300));
        else if ($urandom_range(0, 9) == 0)
            decl_len = decl_len - 24'($urandom_range(0, body.size()));
        hello_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : HELLO_TYPE);
        hello_bytes.push_back(decl_len[23:16]);
        hello_bytes.push_back(decl_len[15:8]);
        hello_bytes.push_back(decl_len[7:0]);
        foreach (body[i])
            hello_bytes.push_back(body[i]);
        if (hc == HC_TRUNCATED)
        begin
            cut = $urandom_range(1, hello_bytes.size() - 1);
            while (hello_bytes.size() > cut)
                void'(hello_bytes.pop_back());
        end
    endtask

    // offers hello_bytes one item at a time, final flag on the last
    task automatic send_hello();
        int gap;
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < hello_bytes.size(); i++)
        begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata <= hello_bytes[i];
            s_tlast <= (i == hello_bytes.size() - 1);
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            sb.note_byte(hello_bytes[i], i == hello_bytes.size() - 1);
        end
    endtask

    initial
    begin : stimulus
        int          hellos;
        int          drain;
        int          pick;
        hello_case_e hc;
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        rst_n = 1'b0;
        hellos = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // messages that stop early: on the type, after the length, inside the random, inside the version
        hello_bytes = '{8'hff};
        send_hello();
        hello_bytes = '{HELLO_TYPE, 8'h00, 8'h00, 8'h00};
        send_hello();
        hello_bytes = '{HELLO_TYPE, 8'hff, 8'hff, 8'hff, 8'h03, 8'h03, 8'h00, 8'hff};
        send_hello();
        hello_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_hello();
        hellos = 4;

        for (int k = 0; k <= int'(HC_NOISE); k++)
        begin
            build_hello(hello_case_e'(k));
            send_hello();
            hellos++;
        end
        while (sb.bytes_noted < BYTE_TARGET)
        begin
            pick = $urandom_range(0, 99);
            hc = (pick < 50) ? HC_PLAIN : (pick < 56) ? HC_NO_EXT :
                 (pick < 60) ? HC_ONE_TAIL_BYTE : (pick < 67) ? HC_OVERRUN :
                 (pick < 74) ? HC_SHORT_TAIL : (pick < 80) ? HC_AFTER_BLOCK :
                 (pick < 87) ? HC_ODD_LIST : (pick < 91) ? HC_LONG_DECL :
                 (pick < 96) ? HC_TRUNCATED : HC_NOISE;
            build_hello(hc);
            send_hello();
            hellos++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        drain = 0;
        while (sb.expected_q.size() > 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10)
            @(posedge clk);
        if (sb.expected_q.size() > 0)
            $display("%0d expected results never arrived", sb.expected_q.size());

        $display("sent %0d hello messages in %0d bytes, mismatches: %0d",
                 hellos, sb.bytes_noted, sb.mismatches);
        $display("predicted %0d extension results and %0d status results (%0d malformed)",
                 sb.ext_results, sb.status_results, sb.malformed);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tls_client_hello_extension_parser: match");
        else
            $display("tls_client_hello_extension_parser: mismatch");
        $finish;
    end

    initial
    begin : result_sink
        int                stall;
        int                taken;
        bit                steady;
        bit                held;
        tchp_pkg::result_t got;
        m_tready = 1'b0;
        taken = 0;
        steady = 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            // one long hold-off lets the result queue fill and back up the input
            if (!held && taken == 20)
            begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1)
                    @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            got.result_kind = m_tuser;
            got.extension_type = m_tdata[15:0];
            got.extension_length = m_tdata[31:16];
            got.parse_status = m_tdata[32];
            got.highest_version = m_tdata[48:33];
            got.extension_count = m_tdata[63:49];
            got.run_end = m_tlast;
            sb.check_result(got);
            taken++;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tls_client_hello_extension_parser: mismatch");
        $finish;
    end

endmodule
